>>> rtl/core/inb_pkg.sv
`timescale 1ns / 1ps
package inb_pkg;

  localparam int RING_DEPTH_DEF   = 8;
  localparam int HANG_SAMPLES_DEF = 7;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int THR1_W     = 13;
  localparam int THR2_W     = 12;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int QUEUE_DEPTH = 4;

  // Q16.16 mean update: avg' = (avg*KEEP + mag*GAIN*2^16) >> 16
  localparam logic [16:0] MEAN_KEEP = 17'd65470;
  localparam logic [6:0]  MEAN_GAIN = 7'd66;
  localparam int          MEAN_ONE  = 65536;

  localparam logic [THR1_W-1:0] THR1_RESET = 13'd768;
  localparam logic [THR2_W-1:0] THR2_RESET = 12'd640;

  typedef enum logic [1:0] {
    REG_EN1  = 2'd0,
    REG_EN2  = 2'd1,
    REG_THR1 = 2'd2,
    REG_THR2 = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              en1;
    logic              en2;
    logic [THR1_W-1:0] thr1;
    logic [THR2_W-1:0] thr2;
  } cfg_t;

  typedef struct packed {
    logic en1;
    logic en2;
  } mode_t;

endpackage

>>> rtl/core/inb_stream_if.sv
`timescale 1ns / 1ps
interface inb_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_i;
  logic signed [W-1:0] sample_q;
  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface inb_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_i;
  logic signed [W-1:0] out_q;
  modport source (output valid, output out_i, output out_q, input ready);
  modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

>>> rtl/core/inb_regs.sv
`timescale 1ns / 1ps
module inb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [inb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [inb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [inb_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output inb_pkg::cfg_t                  cfg
);
  import inb_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.en1  <= 1'b0;
      cfg.en2  <= 1'b0;
      cfg.thr1 <= THR1_RESET;
      cfg.thr2 <= THR2_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_EN1:  cfg.en1  <= pwdata[0];
        REG_EN2:  cfg.en2  <= pwdata[0];
        REG_THR1: cfg.thr1 <= pwdata[THR1_W-1:0];
        REG_THR2: cfg.thr2 <= pwdata[THR2_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_EN1:  prdata[0] = cfg.en1;
      REG_EN2:  prdata[0] = cfg.en2;
      REG_THR1: prdata[THR1_W-1:0] = cfg.thr1;
      REG_THR2: prdata[THR2_W-1:0] = cfg.thr2;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/inb_front.sv
`timescale 1ns / 1ps
module inb_front #(
  parameter int W = inb_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  inb_in_if.sink          in_ch,
  input  inb_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            q_push,
  output logic [2*W+1:0]  q_data
);
  import inb_pkg::*;

  logic           held;
  mode_t          mode;
  logic [2*W-1:0] pay;

  assign q_push      = held && !q_full;
  assign in_ch.ready = !held || !q_full;
  assign q_data      = {mode, pay};

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      held <= 1'b1;
    end else if (q_push) begin
      held <= 1'b0;
    end
  end

  // tag each sample with the blankers that are on when it arrives
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mode.en1 <= cfg.en1;
      mode.en2 <= cfg.en2;
      pay      <= {in_ch.sample_i, in_ch.sample_q};
    end
  end

endmodule

>>> rtl/core/inb_queue.sv
`timescale 1ns / 1ps
module inb_queue #(
  parameter int DW    = 34,
  parameter int DEPTH = inb_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] slots [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] cnt;
  logic          do_push, do_pop;

  assign full    = cnt == CW'(DEPTH);
  assign empty   = cnt == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (do_pop)  rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wp] <= wdata;
  end

endmodule

>>> rtl/core/inb_back.sv
`timescale 1ns / 1ps
module inb_back #(
  parameter int W            = inb_pkg::SAMPLE_WIDTH_DEF,
  parameter int RING_DEPTH   = inb_pkg::RING_DEPTH_DEF,
  parameter int HANG_SAMPLES = inb_pkg::HANG_SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  inb_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  logic [2*W+1:0] q_data,
  output logic           q_pop,
  inb_out_if.source      out_ch
);
  import inb_pkg::*;

  localparam int PW    = $clog2(RING_DEPTH);
  localparam int HW    = $clog2(HANG_SAMPLES + 1);
  localparam int SCW   = $clog2(W + 1);
  localparam int AVG_W = W + 16;
  localparam int SUM_W = AVG_W + 17;
  localparam int CMP_W = AVG_W + THR1_W;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b00000001,
    ST_SQUARE  = 8'b00000010,
    ST_SUM     = 8'b00000100,
    ST_ROOT    = 8'b00001000,
    ST_MEAN    = 8'b00010000,
    ST_COMPARE = 8'b00100000,
    ST_APPLY   = 8'b01000000,
    ST_EMIT    = 8'b10000000
  } state_t;

  state_t              state;
  mode_t               mode;
  logic                phase;
  logic signed [W-1:0] cur_i, cur_q;
  logic [2*W-1:0]      sq_i, sq_q, rem, root, rbit;
  logic [SCW-1:0]      step;
  logic [W-1:0]        mag;
  logic [AVG_W-1:0]    mean1, mean2;
  logic                above;
  logic [2*W-1:0]      ring [RING_DEPTH];
  logic [PW-1:0]       wp, rp;
  logic [HW-1:0]       hang;
  logic signed [W-1:0] msi, msq;

  logic signed [2*W-1:0] p_i, p_q;
  logic [2*W-1:0]        trial;
  logic [AVG_W-1:0]      avg_sel;
  logic [SUM_W-1:0]      mean_sum;
  logic [THR1_W-1:0]     thr_sel;
  logic [CMP_W-1:0]      lhs, rhs;
  logic [HW-1:0]         hang_eff;
  logic [W+2:0]          acc_i, acc_q;
  logic signed [W-1:0]   msi_next, msq_next;
  logic                  emit;

  assign p_i      = cur_i * cur_i;
  assign p_q      = cur_q * cur_q;
  assign trial    = root + rbit;
  assign avg_sel  = phase ? mean2 : mean1;
  assign mean_sum = SUM_W'(avg_sel) * SUM_W'(MEAN_KEEP)
                  + ((SUM_W'(mag) * SUM_W'(MEAN_GAIN)) << 16);
  assign thr_sel  = phase ? {1'b0, cfg.thr2} : cfg.thr1;
  assign lhs      = CMP_W'(mag) << 24;
  assign rhs      = CMP_W'(thr_sel) * CMP_W'(avg_sel);
  assign above    = lhs > rhs;
  assign hang_eff = (hang == '0 && above) ? HW'(HANG_SAMPLES) : hang;
  // floor((3*s + x) / 4): arithmetic shift of the sign-extended sum
  assign acc_i    = {{3{msi[W-1]}}, msi} + {{2{msi[W-1]}}, msi, 1'b0}
                  + {{3{cur_i[W-1]}}, cur_i};
  assign acc_q    = {{3{msq[W-1]}}, msq} + {{2{msq[W-1]}}, msq, 1'b0}
                  + {{3{cur_q[W-1]}}, cur_q};
  assign msi_next = acc_i[W+1:2];
  assign msq_next = acc_q[W+1:2];

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign emit  = (state == ST_EMIT) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      phase  <= 1'b0;
      wp     <= '0;
      rp     <= PW'(2 % RING_DEPTH);
      hang   <= '0;
      mean1  <= AVG_W'(MEAN_ONE);
      mean2  <= AVG_W'(MEAN_ONE);
      msi    <= '0;
      msq    <= '0;
      for (int k = 0; k < RING_DEPTH; k++) ring[k] <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            {mode, cur_i, cur_q} <= q_data;
            if (q_data[2*W+1]) begin
              phase <= 1'b0;
              state <= ST_SQUARE;
            end else if (q_data[2*W]) begin
              phase <= 1'b1;
              state <= ST_SQUARE;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_SQUARE: begin
          sq_i  <= p_i;
          sq_q  <= p_q;
          state <= ST_SUM;
        end
        ST_SUM: begin
          rem   <= sq_i + sq_q;
          root  <= '0;
          rbit  <= (2*W)'(1) << (2*W - 2);
          step  <= SCW'(W - 1);
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (rem >= trial) begin
            rem  <= rem - trial;
            root <= (root >> 1) + rbit;
          end else begin
            root <= root >> 1;
          end
          rbit <= rbit >> 2;
          if (step == '0) state <= ST_MEAN;
          else step <= step - 1'b1;
        end
        ST_MEAN: begin
          mag <= root[W-1:0];
          state <= ST_COMPARE;
        end
        ST_COMPARE: begin
          // mean is updated first; the trigger compares against the new mean
          if (phase) mean2 <= mean_sum[AVG_W+15:16];
          else       mean1 <= mean_sum[AVG_W+15:16];
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          if (!phase) begin
            ring[wp] <= {cur_i, cur_q};
            wp <= (wp == '0) ? PW'(RING_DEPTH - 1) : wp - 1'b1;
            rp <= (rp == '0) ? PW'(RING_DEPTH - 1) : rp - 1'b1;
            if (hang_eff != '0) begin
              cur_i <= '0;
              cur_q <= '0;
              hang  <= hang_eff - 1'b1;
            end else begin
              {cur_i, cur_q} <= ring[rp];
            end
            // hand the output of blanker one on to blanker two
            if (mode.en2) begin
              phase <= 1'b1;
              state <= ST_SQUARE;
            end else begin
              state <= ST_EMIT;
            end
          end else begin
            msi <= msi_next;
            msq <= msq_next;
            if (above) begin
              cur_i <= msi_next;
              cur_q <= msq_next;
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (emit) begin
      out_ch.valid <= 1'b1;
      out_ch.out_i <= cur_i;
      out_ch.out_q <= cur_q;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/iq_impulse_noise_blanker.sv
`timescale 1ns / 1ps
// channel   direction  payload               handshake
// in_ch     in         sample_i, sample_q    valid/ready
// out_ch    out        out_i, out_q          valid/ready
// apb       in         4 registers, 32 bit   psel/penable, pready high
//
// One sample passes the datapath at a time; with a blanker on, its time is set
// by the bit-per-cycle square root, which runs once for each blanker that is on.
// Reset is synchronous, clears the delay ring and sets means and pointers to their start values.
// A four-entry queue sits between input and datapath; input stalls only when
// it is full, and the datapath holds a finished sample until it is taken.
module iq_impulse_noise_blanker #(
  parameter int RING_DEPTH   = inb_pkg::RING_DEPTH_DEF,
  parameter int HANG_SAMPLES = inb_pkg::HANG_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH = inb_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  inb_in_if.sink                         in_ch,
  inb_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [inb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [inb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [inb_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import inb_pkg::*;

  localparam int DW = 2*SAMPLE_WIDTH + 2;

  cfg_t          cfg;
  logic          q_full, q_push, q_pop, q_empty;
  logic [DW-1:0] q_wdata, q_rdata;

  inb_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  inb_front #(.W(SAMPLE_WIDTH)) u_front (
    .clk, .rst, .in_ch, .cfg, .q_full, .q_push, .q_data(q_wdata)
  );

  inb_queue #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  inb_back #(
    .W(SAMPLE_WIDTH), .RING_DEPTH(RING_DEPTH), .HANG_SAMPLES(HANG_SAMPLES)
  ) u_back (
    .clk, .rst, .cfg, .q_empty, .q_data(q_rdata), .q_pop, .out_ch
  );

endmodule

>>> rtl/core/inb_checker.sv
`timescale 1ns / 1ps
module inb_checker #(
  parameter int W = inb_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [W-1:0]                   out_i,
  input logic [W-1:0]                   out_q,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [inb_pkg::APB_ADDR_W-1:0] paddr,
  input logic [inb_pkg::APB_DATA_W-1:0] pwdata,
  input logic [inb_pkg::APB_DATA_W-1:0] prdata
);
  import inb_pkg::*;

  logic wr;
  assign wr = psel && penable && pwrite;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_i) && $stable(out_q))
    else $error("stalled result changed");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  a_thr1_read: assert property (@(posedge clk) disable iff (rst)
    wr && paddr[3:2] == REG_THR1 |=>
      (paddr[3:2] != REG_THR1 || prdata[THR1_W-1:0] == $past(pwdata[THR1_W-1:0])))
    else $error("threshold one readback mismatch");

  a_en1_read: assert property (@(posedge clk) disable iff (rst)
    wr && paddr[3:2] == REG_EN1 |=>
      (paddr[3:2] != REG_EN1 || prdata[0] == $past(pwdata[0])))
    else $error("enable one readback mismatch");

endmodule

bind iq_impulse_noise_blanker inb_checker #(.W(SAMPLE_WIDTH)) u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_i(out_ch.out_i), .out_q(out_ch.out_q),
  .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
  .pwdata(pwdata), .prdata(prdata)
);

>>> test/tb_iq_impulse_noise_blanker.sv
`timescale 1ns / 1ps
module tb_iq_impulse_noise_blanker;
  import inb_pkg::*;

  localparam int W = SAMPLE_WIDTH_DEF;
  localparam int DEPTH = RING_DEPTH_DEF;
  localparam int HANG = HANG_SAMPLES_DEF;
  localparam int RP_W = $clog2(DEPTH);
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic signed [W-1:0] i;
    logic signed [W-1:0] q;
  } iq_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  inb_in_if #(.W(W)) in_ch ();
  inb_out_if #(.W(W)) out_ch ();

  iq_impulse_noise_blanker uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic mdl_en1 = 1'b0;
  logic mdl_en2 = 1'b0;
  logic [THR1_W-1:0] mdl_thr1 = THR1_RESET;
  logic [THR2_W-1:0] mdl_thr2 = THR2_RESET;
  iq_t ring [DEPTH];
  logic [RP_W-1:0] wr_pos, rd_pos;
  int unsigned hang_left;
  longint unsigned mag_avg1, mag_avg2;
  int sig_avg_i, sig_avg_q;

  iq_t pending_samples[$];
  iq_t expected_out[$];
  int errors = 0;
  longint cycles = 0;
  bit long_hold = 1'b0;
  bit drain_hold = 1'b0;
  bit in_fire = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("iq_impulse_noise_blanker verification failed");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned iq_mag(int si, int sq);
    longint a = si;
    longint b = sq;
    return int_sqrt(longint'(a * a + b * b));
  endfunction

  function automatic longint unsigned avg_step(longint unsigned avg, longint unsigned m);
    return (avg * 65470 + m * 66 * 65536) >> 16;
  endfunction

  function automatic bit over_thr(longint unsigned m, int unsigned thr, longint unsigned avg);
    return (m << 24) > longint'(thr) * avg;
  endfunction

  function automatic int quarter_floor(int s);
    return s >>> 2;
  endfunction

  function automatic void reset_blanker();
    foreach (ring[k]) ring[k] = '0;
    wr_pos = '0;
    rd_pos = RP_W'(2 % DEPTH);
    hang_left = 0;
    mag_avg1 = MEAN_ONE;
    mag_avg2 = MEAN_ONE;
    sig_avg_i = 0;
    sig_avg_q = 0;
  endfunction

  function automatic iq_t blank_sample(iq_t s);
    int si, sq;
    longint unsigned m;
    si = int'(s.i);
    sq = int'(s.q);
    if (mdl_en1) begin
      m = iq_mag(si, sq);
      ring[wr_pos] = s;
      mag_avg1 = avg_step(mag_avg1, m);
      if (hang_left == 0 && over_thr(m, int'(mdl_thr1), mag_avg1)) hang_left = HANG;
      if (hang_left > 0) begin
        si = 0;
        sq = 0;
        hang_left--;
      end else begin
        si = int'(ring[rd_pos].i);
        sq = int'(ring[rd_pos].q);
      end
      wr_pos = RP_W'((int'(wr_pos) + DEPTH - 1) % DEPTH);
      rd_pos = RP_W'((int'(rd_pos) + DEPTH - 1) % DEPTH);
    end
    if (mdl_en2) begin
      m = iq_mag(si, sq);
      sig_avg_i = quarter_floor(3 * sig_avg_i + si);
      sig_avg_q = quarter_floor(3 * sig_avg_q + sq);
      mag_avg2 = avg_step(mag_avg2, m);
      if (over_thr(m, int'(mdl_thr2), mag_avg2)) begin
        si = sig_avg_i;
        sq = sig_avg_q;
      end
    end
    return '{i: si[W-1:0], q: sq[W-1:0]};
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // note each input transfer at the edge where it happens
  always @(posedge clk) begin
    in_fire <= !rst && in_ch.valid && in_ch.ready;
  end

  // sender
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.sample_i <= '0;
      in_ch.sample_q <= '0;
      reset_blanker();
    end else if (in_ch.valid && !in_fire) begin
      // hold the offered transfer
    end else begin
      if (in_ch.valid) begin
        expected_out.push_back(blank_sample('{i: in_ch.sample_i, q: in_ch.sample_q}));
        void'(pending_samples.pop_front());
        send_gap = pick_gap();
      end
      if (send_gap > 0) send_gap--;
      if (send_gap == 0 && !drain_hold && pending_samples.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.sample_i <= pending_samples[0].i;
        in_ch.sample_q <= pending_samples[0].q;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver
  int unsigned sink_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.ready || $urandom_range(0, 1)) begin
      sink_gap <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    iq_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_out.size() == 0) begin
        $display("%0t: expected no sample, got i=%0d q=%0d", $time, out_ch.out_i,
                 out_ch.out_q);
        errors++;
      end else begin
        want = expected_out.pop_front();
        if (out_ch.out_i !== want.i)
          $display("%0t: out_i expected %0d got %0d", $time, want.i, out_ch.out_i);
        if (out_ch.out_q !== want.q)
          $display("%0t: out_q expected %0d got %0d", $time, want.q, out_ch.out_q);
        if (out_ch.out_i !== want.i || out_ch.out_q !== want.q) errors++;
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_EN1: mdl_en1 = value[0];
      REG_EN2: mdl_en2 = value[0];
      REG_THR1: mdl_thr1 = value[THR1_W-1:0];
      REG_THR2: mdl_thr2 = value[THR2_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() > 0 || in_ch.valid || expected_out.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic iq_t rand_sample();
    int unsigned kind;
    iq_t s;
    kind = $urandom_range(0, 9);
    s.i = W'($urandom);
    s.q = W'($urandom);
    if (kind < 6) begin
      // quiet carrier, room for impulses to stand out
      s.i = W'(int'($urandom_range(0, 400)) - 200);
      s.q = W'(int'($urandom_range(0, 400)) - 200);
    end else if (kind == 6) begin
      s.i = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      s.q = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    return s;
  endfunction

  task automatic run_phase(logic e1, logic e2, int unsigned t1, int unsigned t2, int n);
    reg_write(REG_EN1, APB_DATA_W'(e1));
    reg_write(REG_EN2, APB_DATA_W'(e2));
    reg_write(REG_THR1, t1);
    reg_write(REG_THR2, t2);
    repeat (n) pending_samples.push_back(rand_sample());
    wait_idle();
  endtask

  initial begin
    iq_t d;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes with default settings, then impulses with both on
    pending_samples.push_back('{i: 16'sh7fff, q: 16'sh7fff});
    pending_samples.push_back('{i: 16'sh8000, q: 16'sh8000});
    pending_samples.push_back('{i: 16'sh8000, q: 16'sh7fff});
    pending_samples.push_back('{i: '0, q: '0});
    pending_samples.push_back('{i: -16'sd1, q: 16'sd1});
    wait_idle();
    reg_write(REG_EN1, 1);
    reg_write(REG_EN2, 1);
    for (int k = 0; k < 18; k++) begin
      d.i = (k == 6 || k == 15) ? 16'sh7fff : W'(k * 10 - 50);
      d.q = (k == 6) ? 16'sh8000 : W'(-k);
      pending_samples.push_back(d);
    end
    wait_idle();

    // fill the queue against a stalled receiver
    long_hold = 1'b1;
    repeat (30) pending_samples.push_back(rand_sample());
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
    wait_idle();

    run_phase(1, 0, 256, 640, 80);
    run_phase(1, 0, 8191, 0, 60);
    run_phase(0, 1, 768, 0, 80);
    run_phase(0, 1, 768, 4095, 60);
    run_phase(1, 1, 5120, 3840, 80);
    run_phase(1, 1, 300, 100, 100);

    // sender pauses mid-stream until everything has drained
    repeat (20) pending_samples.push_back(rand_sample());
    repeat (60) @(posedge clk);
    drain_hold = 1'b1;
    while (in_ch.valid || expected_out.size() > 0) @(posedge clk);
    drain_hold = 1'b0;
    wait_idle();

    run_phase(0, 0, 1000, 1000, 40);
    run_phase(1, 1, 768, 640, 100);

    if (errors == 0) begin
      $display("iq_impulse_noise_blanker verification clean");
    end else begin
      $display("iq_impulse_noise_blanker verification failed");
    end
    $finish;
  end

endmodule
